### rtl/fpa_pkg.sv
package fpa_pkg;

  // Default number of fraction bits
  localparam int FRAC_BITS_DEF = 8;

  // Divider depth: one quotient bit per stage
  localparam int DIV_STEPS = 32;

  // Action codes
  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_MIN      = 4'd4,
    ACT_MAX      = 4'd5,
    ACT_INC      = 4'd6,
    ACT_DEC      = 4'd7,
    ACT_FROM_INT = 4'd8,
    ACT_TO_INT   = 4'd9
  } action_t;

  // Input transaction
  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } request_t;

  // Output transaction
  typedef struct packed {
    logic signed [31:0] result;
    logic               a_greater;
    logic               a_less;
    logic               a_equal;
    logic               overflow;
    logic               divide_by_zero;
  } response_t;

  // One divider stage: partial remainder, dividend/quotient shift word, divisor
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] den;
  } div_stage_t;

  // Apply sign to a magnitude and clamp to 32 bits; returns {saturated, value}
  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] m);
    logic [32:0] r;
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(~m[31:0] + 32'd1)};
    end else begin
      if (m > 64'h0000_0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, m[31:0]};
    end
    return r;
  endfunction

endpackage

### rtl/fpa_div_pipe.sv
module fpa_div_pipe (
  input  logic                   clk,
  input  fpa_pkg::div_stage_t    init,
  output fpa_pkg::div_stage_t    fin
);

  fpa_pkg::div_stage_t stg [fpa_pkg::DIV_STEPS];

  // Restoring division step: shift in one dividend bit, subtract if it fits
  function automatic fpa_pkg::div_stage_t step(input fpa_pkg::div_stage_t s);
    fpa_pkg::div_stage_t o;
    logic [32:0] t;
    t = {s.rem, s.quo[31]};
    o.den = s.den;
    if (t >= {1'b0, s.den}) begin
      o.rem = 32'(t - {1'b0, s.den});
      o.quo = {s.quo[30:0], 1'b1};
    end else begin
      o.rem = t[31:0];
      o.quo = {s.quo[30:0], 1'b0};
    end
    return o;
  endfunction

  // Stage chain
  always_ff @(posedge clk) begin
    stg[0] <= step(init);
    for (int i = 1; i < fpa_pkg::DIV_STEPS; i++) begin
      stg[i] <= step(stg[i-1]);
    end
  end

  assign fin = stg[fpa_pkg::DIV_STEPS-1];

endmodule

### rtl/fixed_point_alu_unit.sv
// Pipelined signed 32-bit fixed-point ALU.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. busy is always low, so one transaction may enter every
// cycle. The request struct carries the action code and two raw operands.
// Result channel: done is high for exactly one cycle with the response
// struct (result plus greater/less/equal, overflow and divide-by-zero
// flags). The receiver cannot hold results off and needs none: every
// transaction passes through the stage 1 register, the divider stages and
// the output register and leaves in the order it came.
// Throughput is one transaction per cycle. The depth is set by the divider,
// which resolves one quotient bit per stage over 32 stages; every action
// goes through the same depth so order is kept.
// Reset clears the valid bits of every stage; transactions in flight are
// dropped and done stays low until new transactions come out.
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fpa_pkg::request_t   request,
  output logic                done,
  output fpa_pkg::response_t  response
);

  localparam int STEPS = fpa_pkg::DIV_STEPS;
  localparam int LATENCY = STEPS + 2;
  localparam logic [63:0] HALF = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
  localparam logic [31:0] TRUNC_BIAS = 32'((64'd1 << FRAC_BITS) - 64'd1);

  typedef struct packed {
    logic [3:0]  act;
    logic        gt;
    logic        lt;
    logic        eq;
    logic [31:0] res;
    logic        ovf;
    logic        dz;
    logic        live;
    logic        neg;
    logic [63:0] prod;
    logic [63:0] num;
    logic [31:0] den;
  } stage1_t;

  typedef struct packed {
    logic [3:0]  act;
    logic        gt;
    logic        lt;
    logic        eq;
    logic [31:0] res;
    logic        ovf;
    logic        dz;
    logic        live;
    logic        neg;
  } side_t;

  logic                accept;
  stage1_t             s1_next, s1;
  logic                s1_valid;
  side_t               side [STEPS];
  logic [STEPS-1:0]    side_valid;
  side_t               side0_next;
  fpa_pkg::div_stage_t div_init, div_fin;
  fpa_pkg::response_t  response_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: decode, magnitudes, simple actions, multiply
  always_comb begin
    logic signed [31:0] a, b;
    logic [31:0] mag_a, mag_b;
    logic [63:0] num;
    logic [32:0] sat;
    a = request.operand_a;
    b = request.operand_b;
    mag_a = a[31] ? 32'(~a + 32'sd1) : a;
    mag_b = b[31] ? 32'(~b + 32'sd1) : b;
    num = {32'd0, mag_a} << FRAC_BITS;
    sat = fpa_pkg::sat_mag(a[31], num);
    s1_next.act  = request.action;
    s1_next.gt   = a > b;
    s1_next.lt   = a < b;
    s1_next.eq   = a == b;
    s1_next.res  = 32'd0;
    s1_next.ovf  = 1'b0;
    s1_next.dz   = 1'b0;
    s1_next.live = 1'b0;
    s1_next.neg  = a[31] ^ b[31];
    s1_next.prod = {32'd0, mag_a} * {32'd0, mag_b};
    s1_next.num  = num;
    s1_next.den  = mag_b;
    case (fpa_pkg::action_t'(request.action))
      fpa_pkg::ACT_ADD: s1_next.res = a + b;
      fpa_pkg::ACT_SUB: s1_next.res = a - b;
      fpa_pkg::ACT_MUL: s1_next.res = 32'd0;
      fpa_pkg::ACT_DIV: begin
        if (b == 32'sd0) begin
          s1_next.dz  = 1'b1;
          s1_next.ovf = 1'b1;
          s1_next.res = a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (num[63:32] >= mag_b) begin
          s1_next.ovf = 1'b1;
          s1_next.res = s1_next.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          s1_next.live = 1'b1;
        end
      end
      fpa_pkg::ACT_MIN: s1_next.res = (a < b) ? a : b;
      fpa_pkg::ACT_MAX: s1_next.res = (a > b) ? a : b;
      fpa_pkg::ACT_INC: s1_next.res = a + 32'sd1;
      fpa_pkg::ACT_DEC: s1_next.res = a - 32'sd1;
      fpa_pkg::ACT_FROM_INT: begin
        s1_next.res = sat[31:0];
        s1_next.ovf = sat[32];
      end
      fpa_pkg::ACT_TO_INT: begin
        s1_next.res = $signed(a + (a[31] ? TRUNC_BIAS : 32'd0)) >>> FRAC_BITS;
      end
      default: s1_next.res = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= accept;
    s1 <= s1_next;
  end

  // Stage 2: multiply rounding and clamp, divider entry
  always_comb begin
    logic [32:0] sat;
    sat = fpa_pkg::sat_mag(s1.neg, (s1.prod + HALF) >> FRAC_BITS);
    side0_next.act  = s1.act;
    side0_next.gt   = s1.gt;
    side0_next.lt   = s1.lt;
    side0_next.eq   = s1.eq;
    side0_next.res  = s1.res;
    side0_next.ovf  = s1.ovf;
    side0_next.dz   = s1.dz;
    side0_next.live = s1.live;
    side0_next.neg  = s1.neg;
    if (fpa_pkg::action_t'(s1.act) == fpa_pkg::ACT_MUL) begin
      side0_next.res = sat[31:0];
      side0_next.ovf = sat[32];
    end
  end

  assign div_init.rem = s1.num[63:32];
  assign div_init.quo = s1.num[31:0];
  assign div_init.den = s1.den;

  fpa_div_pipe u_div (
    .clk  (clk),
    .init (div_init),
    .fin  (div_fin)
  );

  // Sideband delay line matched to the divider
  always_ff @(posedge clk) begin
    if (rst) side_valid <= '0;
    else side_valid <= {side_valid[STEPS-2:0], s1_valid};
    side[0] <= side0_next;
    for (int i = 1; i < STEPS; i++) begin
      side[i] <= side[i-1];
    end
  end

  // Final stage: divide rounding and clamp, output register
  always_comb begin
    side_t       sd;
    logic        rnd;
    logic [32:0] sat;
    sd  = side[STEPS-1];
    rnd = {div_fin.rem, 1'b0} >= {1'b0, div_fin.den};
    sat = fpa_pkg::sat_mag(sd.neg, {32'd0, div_fin.quo} + {63'd0, rnd});
    response_next.result         = sd.res;
    response_next.a_greater      = sd.gt;
    response_next.a_less         = sd.lt;
    response_next.a_equal        = sd.eq;
    response_next.overflow       = sd.ovf;
    response_next.divide_by_zero = sd.dz;
    if (sd.live) begin
      response_next.result   = sat[31:0];
      response_next.overflow = sat[32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= side_valid[STEPS-1];
    response <= response_next;
  end

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("transaction did not complete at the fixed latency");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot({response.a_greater, response.a_less, response.a_equal}))
    else $error("comparison flags not one-hot");

  a_dz_ovf: assert property (@(posedge clk) disable iff (rst)
    done && response.divide_by_zero |-> response.overflow)
    else $error("divide by zero without overflow");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC = fpa_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 34;
  localparam int N_RANDOM = 1500;
  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  fpa_pkg::request_t  request;
  logic               done;
  fpa_pkg::response_t response;

  fpa_pkg::request_t  pending_q[$];
  fpa_pkg::response_t expected_q[$];
  int        errors = 0;
  int        checked = 0;
  int        idle_left;
  int        stall_cycles;
  bit        calm_phase;

  fixed_point_alu_unit #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .response(response)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sign and clamp a magnitude to 32 bits
  function automatic logic [32:0] clamp_mag(input bit neg, input logic [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(-m)};
    end
    if (m > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, m[31:0]};
  endfunction

  // Expected ALU response for one request
  function automatic fpa_pkg::response_t alu_predict(input fpa_pkg::request_t rq);
    fpa_pkg::response_t rs;
    longint a, b, p;
    logic [63:0] m, num, den, half;
    logic [32:0] c;
    a = rq.operand_a;
    b = rq.operand_b;
    rs = '0;
    half = (FRAC > 0) ? (64'd1 << (FRAC - 1)) : 64'd0;
    case (rq.action)
      fpa_pkg::ACT_ADD: rs.result = 32'(a + b);
      fpa_pkg::ACT_SUB: rs.result = 32'(a - b);
      fpa_pkg::ACT_MUL: begin
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + half) >> FRAC;
        c = clamp_mag(p < 0, m);
        {rs.overflow, rs.result} = c;
      end
      fpa_pkg::ACT_DIV: begin
        if (b == 0) begin
          rs.divide_by_zero = 1'b1;
          rs.overflow = 1'b1;
          rs.result = (a < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          num = ((a < 0) ? -a : a) << FRAC;
          den = (b < 0) ? -b : b;
          m = (2 * num + den) / (2 * den);
          c = clamp_mag((a < 0) != (b < 0), m);
          {rs.overflow, rs.result} = c;
        end
      end
      fpa_pkg::ACT_MIN: rs.result = 32'((a < b) ? a : b);
      fpa_pkg::ACT_MAX: rs.result = 32'((a > b) ? a : b);
      fpa_pkg::ACT_INC: rs.result = 32'(a + 1);
      fpa_pkg::ACT_DEC: rs.result = 32'(a - 1);
      fpa_pkg::ACT_FROM_INT: begin
        m = ((a < 0) ? -a : a) << FRAC;
        c = clamp_mag(a < 0, m);
        {rs.overflow, rs.result} = c;
      end
      fpa_pkg::ACT_TO_INT: rs.result = 32'(a / (longint'(1) << FRAC));
      default: rs.result = '0;
    endcase
    rs.a_greater = a > b;
    rs.a_less = a < b;
    rs.a_equal = a == b;
    return rs;
  endfunction

  // Random operand biased toward edges and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      3, 4: return 32'($signed($urandom_range(0, 8191)) - 4096);
      5: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_item(input logic [3:0] act, input logic [31:0] a,
                            input logic [31:0] b);
    fpa_pkg::request_t rq;
    rq.action = act;
    rq.operand_a = a;
    rq.operand_b = b;
    pending_q.push_back(rq);
  endtask

  // Stimulus: directed corners, then random transactions
  initial begin
    logic [3:0] act;
    logic [31:0] a, b;
    rst = 1'b1;
    for (int i = 0; i < 10; i++) queue_item(i[3:0], 32'h7FFF_FFFF, 32'h8000_0000);
    queue_item(fpa_pkg::ACT_DIV, 32'd0, 32'd0);
    queue_item(fpa_pkg::ACT_DIV, 32'h8000_0000, 32'd0);
    queue_item(fpa_pkg::ACT_DIV, 32'h0000_0100, 32'h0000_0003);
    queue_item(fpa_pkg::ACT_DIV, 32'hFFFF_FF00, 32'h0000_0003);
    queue_item(fpa_pkg::ACT_MUL, 32'h0000_0080, 32'h0000_0001);
    queue_item(fpa_pkg::ACT_MUL, 32'hFFFF_FF80, 32'h0000_0001);
    queue_item(fpa_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_item(fpa_pkg::ACT_FROM_INT, 32'hFF80_0000, 32'd0);
    queue_item(fpa_pkg::ACT_FROM_INT, 32'h0080_0000, 32'd0);
    queue_item(fpa_pkg::ACT_TO_INT, 32'hFFFF_FF01, 32'd0);
    queue_item(fpa_pkg::ACT_INC, 32'h7FFF_FFFF, 32'd5);
    queue_item(fpa_pkg::ACT_DEC, 32'h8000_0000, 32'd5);
    queue_item(4'd10, 32'd7, 32'd7);
    queue_item(4'd15, 32'hFFFF_FFFF, 32'd0);
    for (int i = 0; i < N_RANDOM; i++) begin
      act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
      a = pick_operand();
      b = ($urandom_range(0, 15) == 0) ? a : pick_operand();
      if (act == fpa_pkg::ACT_DIV && $urandom_range(0, 9) == 0) b = 32'd0;
      queue_item(act, a, b);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Driver: one transaction per cycle, with random idle bursts
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      request <= '0;
      idle_left <= 0;
      calm_phase <= 1'b0;
    end else if (start && busy) begin
      // hold the current transaction
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left <= idle_left - 1;
    end else if (pending_q.size() > 0) begin
      start <= 1'b1;
      request <= pending_q.pop_front();
      if (!calm_phase && $urandom_range(0, 15) == 0) idle_left <= $urandom_range(1, 15);
      calm_phase <= pending_q.size() < 200;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict on acceptance, check each response in order
  always @(posedge clk) begin
    fpa_pkg::response_t exp_rs;
    if (!rst) begin
      if (start && !busy) expected_q.push_back(alu_predict(request));
      if (done) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected response %h", $time, response);
        end else begin
          exp_rs = expected_q.pop_front();
          checked++;
          if (response.result !== exp_rs.result)
            $display("%0t: result expected %h actual %h", $time, exp_rs.result, response.result);
          if (response.a_greater !== exp_rs.a_greater)
            $display("%0t: a_greater expected %b actual %b", $time, exp_rs.a_greater,
                     response.a_greater);
          if (response.a_less !== exp_rs.a_less)
            $display("%0t: a_less expected %b actual %b", $time, exp_rs.a_less, response.a_less);
          if (response.a_equal !== exp_rs.a_equal)
            $display("%0t: a_equal expected %b actual %b", $time, exp_rs.a_equal,
                     response.a_equal);
          if (response.overflow !== exp_rs.overflow)
            $display("%0t: overflow expected %b actual %b", $time, exp_rs.overflow,
                     response.overflow);
          if (response.divide_by_zero !== exp_rs.divide_by_zero)
            $display("%0t: divide_by_zero expected %b actual %b", $time,
                     exp_rs.divide_by_zero, response.divide_by_zero);
          if (response !== exp_rs) errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction accepted on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (!rst && stall_cycles >= STALL_LIMIT) begin
      $display("fixed_point_alu_unit: mismatch");
      $finish;
    end
  end

  // End of run: drain, let the pipeline settle, then report
  initial begin
    wait (!rst);
    wait (pending_q.size() == 0 && !start);
    wait (expected_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Checked %0d transactions: all actions, saturation, rounding,", checked);
    $display("divide by zero, unused codes and comparison flags.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("fixed_point_alu_unit: match");
    end else begin
      $display("fixed_point_alu_unit: mismatch");
    end
    $finish;
  end

endmodule
